### hdl/mips_subset_single_cycle_core_macros.svh
// Assertion macros shared by the core RTL.
// Used by mips_subset_single_cycle_core; expects a clock named clk and reset rst.
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

// same-cycle implication
`define MSCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mscc_pkg.sv
// Shared types and constants for the MIPS subset core.
// No dependencies; imported by mscc_if, mscc_alu and the core.
`default_nettype none

package mscc_pkg;

  localparam int unsigned MSCC_DATA_MEM_BYTES = 4096;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] HALT_WORD = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_PRELOAD = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [2:0] ALU_ADDU = 3'd1;
  localparam logic [2:0] ALU_SUBU = 3'd3;
  localparam logic [2:0] ALU_AND  = 3'd4;
  localparam logic [2:0] ALU_OR   = 3'd5;
  localparam logic [2:0] ALU_NOR  = 3'd7;

endpackage

`default_nettype wire

### hdl/mscc_if.sv
// Request and response channel interfaces of the MIPS subset core.
// Depends on mscc_pkg for the word width.
`default_nettype none

interface mscc_req_if import mscc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [WORD_W-1:0] instruction;
  logic [11:0]       mem_address;
  logic [WORD_W-1:0] mem_value;

  modport source (output valid, command, instruction, mem_address, mem_value, input ready);
  modport sink (input valid, command, instruction, mem_address, mem_value, output ready);
endinterface

interface mscc_rsp_if import mscc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WORD_W-1:0]    next_pc;
  logic                 halted;
  logic                 reg_write_valid;
  logic [REG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    reg_value;
  logic                 store_valid;
  logic [11:0]          store_address;
  logic [WORD_W-1:0]    read_value;

  modport source (output valid, next_pc, halted, reg_write_valid, reg_index, reg_value,
                  store_valid, store_address, read_value, input ready);
  modport sink (input valid, next_pc, halted, reg_write_valid, reg_index, reg_value,
                store_valid, store_address, read_value, output ready);
endinterface

`default_nettype wire

### hdl/mscc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module mscc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/mscc_alu.sv
// R-type ALU of the MIPS subset core, op selected by funct bits 2..0.
// Depends on mscc_pkg for the op codes.
`default_nettype none

module mscc_alu import mscc_pkg::*; (
  input  wire logic [2:0]        sel,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output      logic [WORD_W-1:0] y
);

  always_comb begin
    unique case (sel)
      ALU_ADDU: y = a + b;
      ALU_SUBU: y = a - b;
      ALU_AND:  y = a & b;
      ALU_OR:   y = a | b;
      ALU_NOR:  y = ~(a | b);
      default:  y = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/mips_subset_single_cycle_core.sv
// MIPS subset core: one transaction in and one out per clock while the response side is ready.
// Register file read at accept, execute and data memory access in the execute stage (s1),
// data memory read data lands with the result register (s2), written back as the result leaves.
// Both stages hold while a valid result waits on rsp.ready.
// Reset clears the program counter, halt flag, register valid bits and stage valid flags;
// data memory is not cleared and reads as undefined until written.
`default_nettype none

`include "mips_subset_single_cycle_core_macros.svh"

module mips_subset_single_cycle_core import mscc_pkg::*; #(
  parameter int unsigned DATA_MEM_BYTES = MSCC_DATA_MEM_BYTES
) (
  input wire logic   clk,
  input wire logic   rst,
  mscc_req_if.sink   req,
  mscc_rsp_if.source rsp
);

  localparam int unsigned MemWords = DATA_MEM_BYTES / 4;
  localparam int unsigned IdxW = $clog2(MemWords);

  logic advance;

  // architectural state
  logic [WORD_W-1:0]    pc;
  logic                 halt_seen;
  logic [REG_COUNT-1:0] rf_valid;

  // execute stage
  logic                 s1_valid;
  cmd_t                 s1_cmd;
  logic [WORD_W-1:0]    s1_instr;
  logic [11:0]          s1_mem_address;
  logic [WORD_W-1:0]    s1_mem_value;

  // result stage
  logic                 s2_valid;
  logic [WORD_W-1:0]    s2_next_pc;
  logic                 s2_halted;
  logic                 s2_reg_write_valid;
  logic [REG_IDX_W-1:0] s2_reg_index;
  logic [WORD_W-1:0]    s2_reg_value;
  logic                 s2_is_load;
  logic                 s2_store_valid;
  logic [11:0]          s2_store_address;
  logic                 s2_use_mem;

  // last completed register write
  logic                 s3_valid;
  logic [REG_IDX_W-1:0] s3_index;
  logic [WORD_W-1:0]    s3_value;

  logic [WORD_W-1:0]    rf_a_rdata, rf_b_rdata, dm_rdata;
  logic [WORD_W-1:0]    wb_value;
  logic                 wb_en;

  logic [5:0]           opcode;
  logic [REG_IDX_W-1:0] rs, rt, rd;
  logic [WORD_W-1:0]    sext, op_a, op_b, alu_y, pc4, eff_addr, maddr_ext, st_byte;
  logic [IdxW-1:0]      eff_idx, maddr_idx;

  logic [WORD_W-1:0]    pc_next;
  logic                 halt_next;
  logic                 wr, ld, st, use_mem;
  logic [REG_IDX_W-1:0] wr_idx;
  logic [WORD_W-1:0]    wr_val;
  logic                 dm_we, dm_re;
  logic [IdxW-1:0]      dm_addr;
  logic [WORD_W-1:0]    dm_wdata;

  assign advance = !s2_valid || rsp.ready;
  // hold off the source while in reset
  assign req.ready = advance && !rst;

  assign wb_value = s2_is_load ? dm_rdata : s2_reg_value;
  assign wb_en = advance && s2_valid && s2_reg_write_valid;

  mscc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s2_reg_index),
    .wdata (wb_value),
    .re    (advance),
    .raddr (req.instruction[25:21]),
    .rdata (rf_a_rdata)
  );

  mscc_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s2_reg_index),
    .wdata (wb_value),
    .re    (advance),
    .raddr (req.instruction[20:16]),
    .rdata (rf_b_rdata)
  );

  mscc_ram #(.WIDTH(WORD_W), .DEPTH(MemWords)) u_dmem (
    .clk   (clk),
    .we    (dm_we && advance && s1_valid),
    .waddr (dm_addr),
    .wdata (dm_wdata),
    .re    (dm_re && advance && s1_valid),
    .raddr (dm_addr),
    .rdata (dm_rdata)
  );

  assign opcode = s1_instr[31:26];
  assign rs = s1_instr[25:21];
  assign rt = s1_instr[20:16];
  assign rd = s1_instr[15:11];
  assign sext = {{16{s1_instr[15]}}, s1_instr[15:0]};

  // forward writes that the register file read missed
  always_comb begin
    if (s2_valid && s2_reg_write_valid && s2_reg_index == rs) begin
      op_a = wb_value;
    end else if (s3_valid && s3_index == rs) begin
      op_a = s3_value;
    end else if (rf_valid[rs]) begin
      op_a = rf_a_rdata;
    end else begin
      op_a = '0;
    end
  end

  always_comb begin
    if (s2_valid && s2_reg_write_valid && s2_reg_index == rt) begin
      op_b = wb_value;
    end else if (s3_valid && s3_index == rt) begin
      op_b = s3_value;
    end else if (rf_valid[rt]) begin
      op_b = rf_b_rdata;
    end else begin
      op_b = '0;
    end
  end

  mscc_alu u_alu (
    .sel (s1_instr[2:0]),
    .a   (op_a),
    .b   (op_b),
    .y   (alu_y)
  );

  assign pc4 = pc + 32'd4;
  assign eff_addr = op_a + sext;
  assign eff_idx = eff_addr[IdxW+1:2];
  assign maddr_ext = 32'(s1_mem_address);
  assign maddr_idx = maddr_ext[IdxW+1:2];
  assign st_byte = 32'({eff_idx, 2'b00});

  always_comb begin
    pc_next = pc;
    halt_next = halt_seen;
    wr = 1'b0;
    wr_idx = '0;
    wr_val = '0;
    ld = 1'b0;
    st = 1'b0;
    use_mem = 1'b0;
    dm_we = 1'b0;
    dm_re = 1'b0;
    dm_addr = maddr_idx;
    dm_wdata = s1_mem_value;
    unique case (s1_cmd)
      CMD_PRELOAD: begin
        dm_we = 1'b1;
      end
      CMD_READ: begin
        dm_re = 1'b1;
        use_mem = 1'b1;
      end
      CMD_EXEC: begin
        if (!halt_seen) begin
          if (s1_instr == HALT_WORD) begin
            halt_next = 1'b1;
          end else begin
            pc_next = pc4;
            unique case (opcode)
              OP_RTYPE: begin
                wr = (rd != '0);
                wr_idx = rd;
                wr_val = alu_y;
              end
              OP_ADDIU: begin
                wr = (rt != '0);
                wr_idx = rt;
                wr_val = eff_addr;
              end
              OP_LW: begin
                wr = (rt != '0);
                wr_idx = rt;
                ld = (rt != '0);
                use_mem = 1'b1;
                dm_re = 1'b1;
                dm_addr = eff_idx;
              end
              OP_SW: begin
                st = 1'b1;
                dm_we = 1'b1;
                dm_addr = eff_idx;
                dm_wdata = op_b;
              end
              OP_BEQ: begin
                if (op_a == op_b) begin
                  pc_next = pc4 + {sext[29:0], 2'b00};
                end
              end
              OP_J: begin
                pc_next = {pc4[31:28], s1_instr[25:0], 2'b00};
              end
              default: ;
            endcase
            if (!wr) begin
              wr_idx = '0;
              wr_val = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      pc <= '0;
      halt_seen <= 1'b0;
      rf_valid <= '0;
    end else if (advance) begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        pc <= pc_next;
        halt_seen <= halt_next;
      end
      if (wb_en) begin
        s3_valid <= 1'b1;
        rf_valid[s2_reg_index] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd <= cmd_t'(req.command);
      s1_instr <= req.instruction;
      s1_mem_address <= req.mem_address;
      s1_mem_value <= req.mem_value;
      s2_next_pc <= pc_next;
      s2_halted <= halt_next;
      s2_reg_write_valid <= wr;
      s2_reg_index <= wr_idx;
      s2_reg_value <= wr_val;
      s2_is_load <= ld;
      s2_store_valid <= st;
      s2_store_address <= st ? st_byte[11:0] : 12'd0;
      s2_use_mem <= use_mem;
      if (wb_en) begin
        s3_index <= s2_reg_index;
        s3_value <= wb_value;
      end
    end
  end

  assign rsp.valid = s2_valid;
  assign rsp.next_pc = s2_next_pc;
  assign rsp.halted = s2_halted;
  assign rsp.reg_write_valid = s2_reg_write_valid;
  assign rsp.reg_index = s2_reg_index;
  assign rsp.reg_value = wb_value;
  assign rsp.store_valid = s2_store_valid;
  assign rsp.store_address = s2_store_address;
  assign rsp.read_value = s2_use_mem ? dm_rdata : '0;

  `MSCC_ASSERT_IMP(a_no_r0_write, s2_valid && s2_reg_write_valid, s2_reg_index != '0, "write to register zero")
  `MSCC_ASSERT_IMP(a_store_xor_write, s2_valid, !(s2_store_valid && s2_reg_write_valid), "store and register write together")
  `MSCC_ASSERT_NEXT(a_halt_sticky, halt_seen, halt_seen, "halt flag cleared without reset")
  `MSCC_ASSERT_NEXT(a_halted_pc_hold, halt_seen && advance && s1_valid, $stable(pc), "program counter moved while halted")
  `MSCC_ASSERT_IMP(a_rf_valid_r0, 1'b1, !rf_valid[0], "register zero marked written")

endmodule

`default_nettype wire

### tb/tb_mips_subset_single_cycle_core.sv
// Self-checking testbench for mips_subset_single_cycle_core.
// Predicts each response from its own architectural model and checks the rsp channel.
// Depends on mscc_pkg and the mscc_req_if / mscc_rsp_if interfaces.
`default_nettype none

module tb_mips_subset_single_cycle_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mscc_pkg::*;

  localparam int unsigned MEM_WORDS    = MSCC_DATA_MEM_BYTES / 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 220;
  localparam logic [2:0]  ALU_NONE     = 3'd0;
  localparam logic [5:0]  OP_UNUSED    = 6'd63;

  typedef struct packed {
    logic [WORD_W-1:0]    next_pc;
    logic                 halted;
    logic                 reg_write_valid;
    logic [REG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    reg_value;
    logic                 store_valid;
    logic [11:0]          store_address;
    logic [WORD_W-1:0]    read_value;
  } core_result_t;

  logic clk;
  logic rst;

  mscc_req_if req_ch ();
  mscc_rsp_if rsp_ch ();

  mips_subset_single_cycle_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Architectural state of the core as the testbench sees it
  logic [WORD_W-1:0] arch_pc;
  logic [WORD_W-1:0] arch_regs [REG_COUNT];
  logic [WORD_W-1:0] arch_mem [MEM_WORDS];
  logic              arch_halt;
  bit                mem_written [MEM_WORDS];
  int unsigned       written_words [$];

  core_result_t pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_len;
  logic        sink_hold;
  event        hold_trigger;

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("mips_subset_single_cycle_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned word_of(logic [WORD_W-1:0] byte_addr);
    return (byte_addr % MSCC_DATA_MEM_BYTES) >> 2;
  endfunction

  function automatic void note_written(int unsigned wi);
    if (!mem_written[wi]) begin
      mem_written[wi] = 1'b1;
      written_words.push_back(wi);
    end
  endfunction

  function automatic logic [WORD_W-1:0] alu(logic [2:0] sel, logic [WORD_W-1:0] a,
                                             logic [WORD_W-1:0] b);
    case (sel)
      ALU_ADDU: return a + b;
      ALU_SUBU: return a - b;
      ALU_AND:  return a & b;
      ALU_OR:   return a | b;
      ALU_NOR:  return ~(a | b);
      default:  return '0;
    endcase
  endfunction

  // Drop writes to register zero; they are reported as no write
  function automatic void put_reg(inout core_result_t r, input logic [4:0] idx,
                                  input logic [WORD_W-1:0] v);
    if (idx != '0) begin
      arch_regs[idx]    = v;
      r.reg_write_valid = 1'b1;
      r.reg_index       = idx;
      r.reg_value       = v;
    end
  endfunction

  function automatic core_result_t retire(logic [1:0] cmd, logic [WORD_W-1:0] instr,
                                          logic [11:0] maddr, logic [WORD_W-1:0] mval);
    core_result_t      r;
    logic [5:0]        opcode;
    logic [4:0]        rs;
    logic [4:0]        rt;
    logic [4:0]        rd;
    logic [WORD_W-1:0] sext;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] pc4;
    logic [WORD_W-1:0] nxt;
    logic [WORD_W-1:0] ea;
    int unsigned       wi;
    r      = '0;
    opcode = instr[31:26];
    rs     = instr[25:21];
    rt     = instr[20:16];
    rd     = instr[15:11];
    sext   = {{16{instr[15]}}, instr[15:0]};
    a      = arch_regs[rs];
    b      = arch_regs[rt];
    pc4    = arch_pc + 32'd4;
    nxt    = pc4;
    ea     = a + sext;
    if (cmd == CMD_PRELOAD) begin
      wi = word_of({20'd0, maddr});
      arch_mem[wi] = mval;
      note_written(wi);
    end else if (cmd == CMD_READ) begin
      r.read_value = arch_mem[word_of({20'd0, maddr})];
    end else if (cmd == CMD_EXEC && !arch_halt) begin
      if (instr == HALT_WORD) begin
        arch_halt = 1'b1;
      end else begin
        case (opcode)
          OP_RTYPE: put_reg(r, rd, alu(instr[2:0], a, b));
          OP_ADDIU: put_reg(r, rt, ea);
          OP_LW: begin
            r.read_value = arch_mem[word_of(ea)];
            put_reg(r, rt, r.read_value);
          end
          OP_SW: begin
            wi = word_of(ea);
            arch_mem[wi] = b;
            note_written(wi);
            r.store_valid   = 1'b1;
            r.store_address = 12'(wi << 2);
          end
          OP_BEQ: if (a == b) nxt = pc4 + (sext << 2);
          OP_J:   nxt = {pc4[31:28], instr[25:0], 2'b00};
          default: ;
        endcase
        arch_pc = nxt;
      end
    end
    r.next_pc = arch_pc;
    r.halted  = arch_halt;
    return r;
  endfunction

  // ------------------------------------------------------------ instruction words

  function automatic logic [WORD_W-1:0] r_word(logic [4:0] rs, logic [4:0] rt,
                                                logic [4:0] rd, logic [2:0] sel);
    return {OP_RTYPE, rs, rt, rd, 5'd0, 3'b100, sel};
  endfunction

  function automatic logic [WORD_W-1:0] i_word(logic [5:0] op, logic [4:0] rs,
                                                logic [4:0] rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [WORD_W-1:0] j_word(logic [25:0] target);
    return {OP_J, target};
  endfunction

  // Aim a load at a word that has been written, whatever rs holds
  function automatic logic [WORD_W-1:0] lw_word(logic [4:0] rs, logic [4:0] rt,
                                                 logic [3:0] hi);
    int unsigned tgt;
    logic [11:0] off;
    tgt = written_words[$urandom_range(written_words.size() - 1)];
    off = 12'(tgt << 2) + 12'($urandom_range(3)) - arch_regs[rs][11:0];
    return i_word(OP_LW, rs, rt, {hi, off});
  endfunction

  function automatic logic [WORD_W-1:0] legalize(logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w;
    if (v == HALT_WORD) v[0] = 1'b0;
    if (v[31:26] == OP_LW) begin
      if (written_words.size() == 0) v[31:26] = OP_ADDIU;
      else v = lw_word(v[25:21], v[20:16], v[15:12]);
    end
    return v;
  endfunction

  // ------------------------------------------------------------------- driving

  task automatic send_item(input logic [1:0] cmd, input logic [WORD_W-1:0] instr,
                           input logic [11:0] maddr, input logic [WORD_W-1:0] mval);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    pending_results.push_back(retire(cmd, instr, maddr, mval));
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.instruction <= instr;
    req_ch.mem_address <= maddr;
    req_ch.mem_value   <= mval;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic exec(input logic [WORD_W-1:0] instr);
    send_item(CMD_EXEC, instr, 12'($urandom), $urandom);
  endtask

  // Mostly well-formed instructions, some data port traffic and noise
  task automatic random_item();
    int unsigned       pick;
    logic [4:0]        rs;
    logic [4:0]        rt;
    logic [2:0]        sel;
    logic [WORD_W-1:0] w;
    pick = $urandom_range(99);
    rs   = 5'($urandom);
    rt   = 5'($urandom);
    if (pick < 12) begin
      send_item(CMD_PRELOAD, $urandom, 12'($urandom), $urandom);
    end else if (pick < 20 && written_words.size() != 0) begin
      w = 32'(written_words[$urandom_range(written_words.size() - 1)]);
      send_item(CMD_READ, $urandom, {w[9:0], 2'($urandom)}, $urandom);
    end else if (pick < 24) begin
      send_item(CMD_NONE, $urandom, 12'($urandom), $urandom);
    end else begin
      pick = $urandom_range(99);
      w    = $urandom;
      if (pick < 25) begin
        case ($urandom_range(6))
          0: sel = ALU_ADDU;
          1: sel = ALU_SUBU;
          2: sel = ALU_AND;
          3: sel = ALU_OR;
          4: sel = ALU_NOR;
          default: sel = 3'($urandom);
        endcase
        w = {OP_RTYPE, w[25:3], sel};
      end else if (pick < 45) begin
        w[31:26] = OP_ADDIU;
      end else if (pick < 60) begin
        w[31:26] = OP_LW;
      end else if (pick < 75) begin
        w[31:26] = OP_SW;
      end else if (pick < 85) begin
        w = i_word(OP_BEQ, rs, $urandom_range(1) ? rs : rt, w[15:0]);
      end else if (pick < 90) begin
        w = j_word(w[25:0]);
      end
      exec(legalize(w));
    end
  endtask

  task automatic release_bus();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------ response side

  initial begin
    sink_hold = 1'b0;
    forever begin
      @(hold_trigger);
      sink_hold = 1'b1;
      repeat (hold_len) @(posedge clk);
      sink_hold = 1'b0;
    end
  end

  always @(negedge clk)
    rsp_ch.ready <= !sink_hold && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : result_check
    core_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected transaction on rsp: next_pc %h", rsp_ch.next_pc);
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.next_pc !== want.next_pc || rsp_ch.halted !== want.halted ||
            rsp_ch.reg_write_valid !== want.reg_write_valid ||
            rsp_ch.reg_index !== want.reg_index || rsp_ch.reg_value !== want.reg_value ||
            rsp_ch.store_valid !== want.store_valid ||
            rsp_ch.store_address !== want.store_address ||
            rsp_ch.read_value !== want.read_value) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch on result %0d", results_seen);
            $display("  exp pc %h h %b rw %b r%0d=%h st %b @%h rd %h", want.next_pc,
                     want.halted, want.reg_write_valid, want.reg_index, want.reg_value,
                     want.store_valid, want.store_address, want.read_value);
            $display("  got pc %h h %b rw %b r%0d=%h st %b @%h rd %h", rsp_ch.next_pc,
                     rsp_ch.halted, rsp_ch.reg_write_valid, rsp_ch.reg_index,
                     rsp_ch.reg_value, rsp_ch.store_valid, rsp_ch.store_address,
                     rsp_ch.read_value);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------- tests

  task automatic test_data_port();
    send_item(CMD_PRELOAD, $urandom, 12'h000, 32'h0000_0000);
    send_item(CMD_PRELOAD, $urandom, 12'hFFF, 32'hFFFF_FFFF);
    send_item(CMD_PRELOAD, $urandom, 12'h7FE, 32'hA5A5_5A5A);
    send_item(CMD_READ, $urandom, 12'h003, $urandom);
    send_item(CMD_READ, $urandom, 12'hFFC, $urandom);
    send_item(CMD_NONE, $urandom, 12'($urandom), $urandom);
  endtask

  task automatic test_alu_ops();
    exec(i_word(OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    exec(i_word(OP_ADDIU, 5'd0, 5'd2, 16'h8000));
    exec(i_word(OP_ADDIU, 5'd1, 5'd3, 16'hFFFF));
    exec(r_word(5'd1, 5'd2, 5'd4, ALU_ADDU));
    exec(r_word(5'd1, 5'd2, 5'd5, ALU_SUBU));
    exec(r_word(5'd1, 5'd2, 5'd6, ALU_AND));
    exec(r_word(5'd1, 5'd2, 5'd7, ALU_OR));
    exec(r_word(5'd1, 5'd2, 5'd31, ALU_NOR));
    exec(r_word(5'd1, 5'd2, 5'd9, ALU_NONE));
    exec(r_word(5'd1, 5'd2, 5'd0, ALU_ADDU));
  endtask

  task automatic test_load_store();
    // negative offset from r0 wraps to the top word
    exec(i_word(OP_SW, 5'd0, 5'd2, 16'hFFFC));
    exec(i_word(OP_LW, 5'd0, 5'd10, 16'hFFFC));
    exec(i_word(OP_SW, 5'd1, 5'd2, 16'h0001));
    exec(i_word(OP_LW, 5'd0, 5'd0, 16'h0000));
  endtask

  task automatic test_control_flow();
    exec(i_word(OP_BEQ, 5'd1, 5'd1, 16'hFFFE));
    exec(i_word(OP_BEQ, 5'd1, 5'd2, 16'h0005));
    exec(j_word(26'h3FF_FFFF));
    exec({OP_UNUSED, 26'd0});
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) random_item();
  endtask

  // Hold the sink off while the source keeps offering, so the core backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 80;
    -> hold_trigger;
    repeat (40) random_item();
  endtask

  // Halt is permanent without reset, so this runs last
  task automatic test_halt();
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    exec(HALT_WORD);
    exec(i_word(OP_ADDIU, 5'd0, 5'd1, 16'h1234));
    exec(i_word(OP_SW, 5'd0, 5'd1, 16'h0100));
    send_item(CMD_PRELOAD, $urandom, 12'h100, $urandom);
    send_item(CMD_READ, $urandom, 12'h100, $urandom);
    send_item(CMD_NONE, $urandom, 12'($urandom), $urandom);
    exec(HALT_WORD);
    repeat (8) random_item();
  endtask

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_EXEC;
    req_ch.instruction = '0;
    req_ch.mem_address = '0;
    req_ch.mem_value   = '0;
    rsp_ch.ready       = 1'b0;
    arch_pc            = '0;
    arch_halt          = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    foreach (mem_written[i]) mem_written[i] = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_len           = 0;
    items_sent         = 0;
    results_seen       = 0;
    error_count        = 0;
    cycle_count        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_data_port();
    test_alu_ops();
    test_load_store();
    test_control_flow();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(19, 19);
    test_backpressure();
    test_halt();

    // Drain outstanding responses, then watch for strays
    release_bus();
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) error_count++;

    $display("Sent %0d transactions in %0d cycles: data port, ALU ops, loads, stores,",
             items_sent, cycle_count);
    $display("branches, jumps, halt, four idle mixes and a long sink hold-off; %0d checked",
             results_seen);
    if (error_count == 0) begin
      $display("mips_subset_single_cycle_core regression: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("mips_subset_single_cycle_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
